// ===== rtl/core/scl_pkg.sv =====
// ----------------------------------------------------------------------------
// scl_pkg
// Types, codes and helpers shared by the scroll axis lock converter.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int MOTION_BITS = 16;
  localparam int PROBE_BITS  = 18;
  localparam int RESID_BITS  = 24;
  localparam int STEP_BITS   = PROBE_BITS + 1;
  localparam int DIV_BITS    = 8;
  localparam int TICK_MAX    = 127;

  localparam logic [1:0] REQ_MOTION = 2'd0;
  localparam logic [1:0] REQ_HOLD   = 2'd1;
  localparam logic [1:0] REQ_TOGGLE = 2'd2;

  localparam logic [1:0] CFG_LOCK_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_SCROLL_DIVISOR = 2'd1;
  localparam logic [1:0] CFG_RELOCK_MS      = 2'd2;

  localparam logic [9:0]  THRESHOLD_RESET = 10'd16;
  localparam logic [7:0]  DIVISOR_RESET   = 8'd12;
  localparam logic [15:0] RELOCK_RESET    = 16'd300;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_VERT = 2'd1,
    AXIS_HORZ = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PROBE,
    ST_LOCK,
    ST_RESID,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               key_pressed;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [7:0]  in_wheel_v;
    logic signed [7:0]  in_wheel_h;
    logic [31:0]        now_ms;
  } req_item_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [7:0]  out_wheel_v;
    logic signed [7:0]  out_wheel_h;
    logic               scroll_on;
  } rsp_item_t;

  function automatic logic signed [15:0] motion_sext(input logic [15:0] v);
    logic signed [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = (i < MOTION_BITS) ? v[i] : v[MOTION_BITS-1];
    end
    return r;
  endfunction

  function automatic logic signed [PROBE_BITS-1:0] sat_probe(
    input logic signed [STEP_BITS-1:0] v
  );
    logic signed [STEP_BITS-1:0] hi;
    logic signed [STEP_BITS-1:0] lo;
    hi = STEP_BITS'((1 <<< (PROBE_BITS - 1)) - 1);
    lo = -STEP_BITS'(1 <<< (PROBE_BITS - 1));
    if (v > hi) return hi[PROBE_BITS-1:0];
    if (v < lo) return lo[PROBE_BITS-1:0];
    return v[PROBE_BITS-1:0];
  endfunction

  function automatic logic signed [RESID_BITS-1:0] sat_resid(
    input logic signed [RESID_BITS:0] v
  );
    if (v[RESID_BITS] != v[RESID_BITS-1]) begin
      return v[RESID_BITS] ? {1'b1, {(RESID_BITS-1){1'b0}}} : {1'b0, {(RESID_BITS-1){1'b1}}};
    end
    return v[RESID_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/scl_div.sv =====
// ----------------------------------------------------------------------------
// scl_div
// Restoring divider, one quotient bit per cycle, for residual magnitudes.
// ----------------------------------------------------------------------------
module scl_div import scl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RESID_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]   divisor,
  output logic                  done,
  output logic [RESID_BITS-1:0] quotient,
  output logic [DIV_BITS-1:0]   remainder
);

  localparam int CNT_BITS = $clog2(RESID_BITS);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [RESID_BITS-1:0] quo;
  logic [DIV_BITS-1:0]   rem;
  logic [DIV_BITS-1:0]   dvs;
  logic [DIV_BITS+1:0]   trial;

  assign trial = {1'b0, rem, quo[RESID_BITS-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_BITS'(RESID_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      quo <= {quo[RESID_BITS-2:0], ~trial[DIV_BITS+1]};
      rem <= trial[DIV_BITS+1] ? {rem[DIV_BITS-2:0], quo[RESID_BITS-1]} : trial[DIV_BITS-1:0];
      cnt <= cnt + CNT_BITS'(1);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== rtl/core/scroll_axis_lock_converter.sv =====
// ----------------------------------------------------------------------------
// scroll_axis_lock_converter
// Key events and pass-through reports go from check to done; scroll motion
// runs probe and lock when no axis is held or it is stale, then residual,
// divider and fix. The next transaction is accepted once the sequencer is
// back in idle, even while the last result waits on rsp_stall.
// Reset: synchronous; mode off, no axis, probes and residual cleared,
// registers back to threshold 16, divisor 12, relock 300 ms.
// ----------------------------------------------------------------------------
module scroll_axis_lock_converter import scl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  fsm_t state;
  fsm_t state_next;

  logic [9:0]  lock_threshold;
  logic [7:0]  scroll_divisor;
  logic [15:0] relock_ms;

  logic                         mode_active;
  axis_t                        locked_axis;
  logic signed [PROBE_BITS-1:0] probe_sum_x;
  logic signed [PROBE_BITS-1:0] probe_sum_y;
  logic signed [RESID_BITS-1:0] tick_residual;
  logic [31:0]                  last_motion_time;

  req_item_t                    item;
  rsp_item_t                    res;
  logic signed [STEP_BITS-1:0]  motion;
  logic [RESID_BITS-1:0]        resid_mag;

  logic signed [15:0]           dxm;
  logic signed [15:0]           dym;
  logic                         stale;
  logic                         zero_motion;
  logic signed [STEP_BITS-1:0]  pxw;
  logic signed [STEP_BITS-1:0]  pyw;
  logic [STEP_BITS-1:0]         ax;
  logic [STEP_BITS-1:0]         ay;
  logic [STEP_BITS-1:0]         probe_mag;
  logic                         below;
  logic signed [RESID_BITS:0]   resid_sum;
  logic signed [RESID_BITS-1:0] resid_sat;
  logic signed [RESID_BITS:0]   resid_w;
  logic [DIV_BITS-1:0]          dvs;
  logic                         div_start;
  logic                         div_done;
  logic [RESID_BITS-1:0]        div_q;
  logic [DIV_BITS-1:0]          div_r;
  logic                         clamp;
  logic [6:0]                   tick_mag;
  logic [14:0]                  d127;
  logic [RESID_BITS-1:0]        new_mag;
  logic [7:0]                   ticks;
  logic                         rsp_load;

  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  assign dxm         = motion_sext(item.dx);
  assign dym         = motion_sext(item.dy);
  assign zero_motion = (dxm == 16'sd0) && (dym == 16'sd0);
  assign stale       = (relock_ms != 16'd0) && (locked_axis != AXIS_NONE) &&
                       ((item.now_ms - last_motion_time) > {16'd0, relock_ms});

  assign pxw       = STEP_BITS'(probe_sum_x);
  assign pyw       = STEP_BITS'(probe_sum_y);
  assign ax        = (pxw < 0) ? STEP_BITS'(-pxw) : STEP_BITS'(pxw);
  assign ay        = (pyw < 0) ? STEP_BITS'(-pyw) : STEP_BITS'(pyw);
  assign probe_mag = ax + ay;
  assign below     = probe_mag < STEP_BITS'(lock_threshold);

  assign resid_sum = (RESID_BITS+1)'(tick_residual) + (RESID_BITS+1)'(motion);
  assign resid_sat = sat_resid(resid_sum);
  assign resid_w   = (RESID_BITS+1)'(resid_sat);
  assign dvs       = (scroll_divisor == 8'd0) ? 8'd1 : scroll_divisor;
  assign div_start = (state == ST_RESID);

  assign clamp    = |div_q[RESID_BITS-1:7];
  assign tick_mag = clamp ? 7'(TICK_MAX) : div_q[6:0];
  assign d127     = {dvs, 7'd0} - {7'd0, dvs};
  assign new_mag  = clamp ? (resid_mag - RESID_BITS'(d127)) : RESID_BITS'(div_r);
  assign ticks    = tick_residual[RESID_BITS-1] ? (8'd0 - {1'b0, tick_mag}) : {1'b0, tick_mag};

  scl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (resid_w[RESID_BITS] ? RESID_BITS'(-resid_w) : RESID_BITS'(resid_w)),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (item.req_type != REQ_MOTION || !mode_active || zero_motion) begin
          state_next = ST_DONE;
        end else if (stale || locked_axis == AXIS_NONE) begin
          state_next = ST_PROBE;
        end else begin
          state_next = ST_RESID;
        end
      end
      ST_PROBE: state_next = ST_LOCK;
      ST_LOCK:  state_next = below ? ST_DONE : ST_RESID;
      ST_RESID: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) state_next = ST_FIX;
      end
      ST_FIX:   state_next = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_threshold <= THRESHOLD_RESET;
      scroll_divisor <= DIVISOR_RESET;
      relock_ms      <= RELOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOCK_THRESHOLD: lock_threshold <= cfg_data[9:0];
        CFG_SCROLL_DIVISOR: scroll_divisor <= cfg_data[7:0];
        CFG_RELOCK_MS:      relock_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_active      <= 1'b0;
      locked_axis      <= AXIS_NONE;
      probe_sum_x      <= '0;
      probe_sum_y      <= '0;
      tick_residual    <= '0;
      last_motion_time <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) item <= req;
        end
        ST_CHECK: begin
          if (item.req_type != REQ_MOTION) begin
            res <= '0;
            if (item.req_type == REQ_HOLD || (item.req_type == REQ_TOGGLE && item.key_pressed)) begin
              mode_active   <= (item.req_type == REQ_HOLD) ? item.key_pressed : !mode_active;
              locked_axis   <= AXIS_NONE;
              probe_sum_x   <= '0;
              probe_sum_y   <= '0;
              tick_residual <= '0;
            end
          end else if (!mode_active) begin
            res <= {dxm, dym, item.in_wheel_v, item.in_wheel_h, 1'b0};
          end else begin
            res <= {16'd0, 16'd0, item.in_wheel_v, item.in_wheel_h, 1'b0};
            if (!zero_motion) begin
              last_motion_time <= item.now_ms;
              if (stale) begin
                locked_axis   <= AXIS_NONE;
                probe_sum_x   <= '0;
                probe_sum_y   <= '0;
                tick_residual <= '0;
              end
              motion <= (locked_axis == AXIS_VERT) ? -STEP_BITS'(dym) : STEP_BITS'(dxm);
            end
          end
        end
        ST_PROBE: begin
          probe_sum_x <= sat_probe(pxw + STEP_BITS'(dxm));
          probe_sum_y <= sat_probe(pyw + STEP_BITS'(dym));
        end
        ST_LOCK: begin
          if (!below) begin
            locked_axis <= (ay >= ax) ? AXIS_VERT : AXIS_HORZ;
            motion      <= (ay >= ax) ? -pyw : pxw;
          end
        end
        ST_RESID: begin
          tick_residual <= resid_sat;
          resid_mag     <= resid_w[RESID_BITS] ? RESID_BITS'(-resid_w) : RESID_BITS'(resid_w);
        end
        ST_FIX: begin
          tick_residual <= tick_residual[RESID_BITS-1] ? (RESID_BITS'(0) - new_mag) : new_mag;
          if (locked_axis == AXIS_VERT) begin
            res.out_wheel_v <= ticks;
          end else begin
            res.out_wheel_h <= ticks;
          end
        end
        ST_DONE: begin
          if (rsp_load) begin
            rsp <= {res.out_x, res.out_y, res.out_wheel_v, res.out_wheel_h, mode_active};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
